[rtl/core/nec_ir_pkg.sv]
// NEC IR frame decoder package: timing constants, field widths and the
// duration window compare shared by the decoder. No dependencies.
`timescale 1ns / 1ps

package nec_ir_pkg;

    localparam int DUR_W    = 15;
    localparam int NOM_W    = 14;
    localparam int MARGIN_W = 12;
    localparam int HALF_W   = 16;
    localparam int DATA_BITS = 2 * HALF_W;

    localparam logic [NOM_W-1:0] LEAD_MARK_US  = 14'd9000;
    localparam logic [NOM_W-1:0] LEAD_SPACE_US = 14'd4500;
    localparam logic [NOM_W-1:0] RPT_SPACE_US  = 14'd2250;
    localparam logic [NOM_W-1:0] BIT_MARK_US   = 14'd560;
    localparam logic [NOM_W-1:0] ZERO_SPACE_US = 14'd560;
    localparam logic [NOM_W-1:0] ONE_SPACE_US  = 14'd1690;

    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 12'd500;

    localparam int FRAME_SYMBOLS  = 34;
    localparam int REPEAT_SYMBOLS = 2;

    // Open window (nominal - margin, nominal + margin); lower bound moved to
    // the duration side so a negative bound needs no sign handling.
    function automatic logic in_window(
        input logic [DUR_W-1:0]    dur,
        input logic [NOM_W-1:0]    nominal,
        input logic [MARGIN_W-1:0] margin
    );
        logic [15:0] upper;
        logic [15:0] dur_plus;
        upper    = 16'(nominal) + 16'(margin);
        dur_plus = 16'(dur) + 16'(margin);
        return (16'(dur) < upper) && (dur_plus > 16'(nominal));
    endfunction

endpackage

[rtl/core/nec_ir_frame_decoder.sv]
// NEC IR frame decoder top level: symbol input register, capture state,
// result register. Depends on nec_ir_pkg.
//
// Channel  Dir  tdata (low bit up)                       tuser / tlast
// s_       in   mark_time[14:0], space_time[29:15]       tlast = end_of_capture
// m_       out  rx_address[15:0], rx_command[31:16]      tuser = frame_ok, repeat_flag
// cfg_     in   cfg_wr_data = margin_us[11:0]            write on cfg_wr_en
//
// One symbol per cycle sustained while s_tready is high; an end-of-capture symbol
// passes the input register, then loads the result register, which drives m_tvalid.
// s_tready drops only while an end-of-capture symbol sits in the input register
// and the result register is full and not being taken.
// aresetn (synchronous, active low) clears capture state, held address and
// command, and sets margin_us to 500.
`timescale 1ns / 1ps

module nec_ir_frame_decoder #(
    parameter int MAX_SYMBOLS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [11:0] cfg_wr_data,   // margin_us
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // mark_time[14:0], space_time[29:15], zero fill
    input  logic        s_tlast,       // end_of_capture
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,       // rx_address[15:0], rx_command[31:16]
    output logic [1:0]  m_tuser        // frame_ok[0], repeat_flag[1]
);

    localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
    localparam int DW    = nec_ir_pkg::DUR_W;

    logic [nec_ir_pkg::MARGIN_W-1:0] margin_reg;

    // input register
    logic          in_valid_reg;
    logic [DW-1:0] in_mark_reg;
    logic [DW-1:0] in_space_reg;
    logic          in_last_reg;

    // capture state
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             leader_reg, leader_next;
    logic             rpt_lead_reg, rpt_lead_next;
    logic             bit_err_reg, bit_err_next;
    logic [nec_ir_pkg::DATA_BITS-1:0] shift_reg, shift_next;
    logic [nec_ir_pkg::HALF_W-1:0]    addr_reg, addr_next;
    logic [nec_ir_pkg::HALF_W-1:0]    cmd_reg, cmd_next;

    // result register
    logic        out_valid_reg;
    logic        out_ok_reg, out_rpt_reg;
    logic [31:0] out_data_reg;

    logic adv;
    logic res_ok, res_rpt;
    logic lead_mark_ok, mark_ok, sym_one, sym_zero, data_pos;

    assign adv      = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;

    assign lead_mark_ok = nec_ir_pkg::in_window(in_mark_reg, nec_ir_pkg::LEAD_MARK_US,
                                                margin_reg);
    assign mark_ok  = nec_ir_pkg::in_window(in_mark_reg, nec_ir_pkg::BIT_MARK_US, margin_reg);
    assign sym_one  = mark_ok && nec_ir_pkg::in_window(in_space_reg,
                                                       nec_ir_pkg::ONE_SPACE_US, margin_reg);
    assign sym_zero = mark_ok && nec_ir_pkg::in_window(in_space_reg,
                                                       nec_ir_pkg::ZERO_SPACE_US, margin_reg);
    assign data_pos = (cnt_reg != '0) && (cnt_reg <= CNT_W'(nec_ir_pkg::DATA_BITS));

    always_comb begin
        leader_next   = leader_reg;
        rpt_lead_next = rpt_lead_reg;
        bit_err_next  = bit_err_reg;
        shift_next    = shift_reg;
        cnt_next      = cnt_reg;
        addr_next     = addr_reg;
        cmd_next      = cmd_reg;
        res_ok        = 1'b0;
        res_rpt       = 1'b0;

        if (cnt_reg == '0) begin
            leader_next   = lead_mark_ok && nec_ir_pkg::in_window(in_space_reg,
                                nec_ir_pkg::LEAD_SPACE_US, margin_reg);
            rpt_lead_next = lead_mark_ok && nec_ir_pkg::in_window(in_space_reg,
                                nec_ir_pkg::RPT_SPACE_US, margin_reg);
        end else if (data_pos) begin
            // data symbols shift in from the top: after 32, bit i is symbol i
            shift_next = {sym_one, shift_reg[nec_ir_pkg::DATA_BITS-1:1]};
            if (!sym_one && !sym_zero) begin
                bit_err_next = 1'b1;
            end
        end

        if (cnt_reg < CNT_W'(MAX_SYMBOLS)) begin
            cnt_next = cnt_reg + 1'b1;
        end

        if (in_last_reg) begin
            // the closing symbol of a frame is never a data symbol,
            // so the registered flags are final here
            if (cnt_next == CNT_W'(nec_ir_pkg::FRAME_SYMBOLS) && leader_reg && !bit_err_reg) begin
                addr_next = shift_reg[nec_ir_pkg::HALF_W-1:0];
                cmd_next  = shift_reg[nec_ir_pkg::DATA_BITS-1:nec_ir_pkg::HALF_W];
                res_ok    = 1'b1;
            end else if (cnt_next == CNT_W'(nec_ir_pkg::REPEAT_SYMBOLS) && rpt_lead_reg) begin
                res_ok  = 1'b1;
                res_rpt = 1'b1;
            end
            cnt_next      = '0;
            leader_next   = 1'b0;
            rpt_lead_next = 1'b0;
            bit_err_next  = 1'b0;
            shift_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            margin_reg    <= nec_ir_pkg::MARGIN_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            leader_reg    <= 1'b0;
            rpt_lead_reg  <= 1'b0;
            bit_err_reg   <= 1'b0;
            shift_reg     <= '0;
            addr_reg      <= '0;
            cmd_reg       <= '0;
        end else begin
            if (cfg_wr_en) begin
                margin_reg <= cfg_wr_data;
            end

            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end

            if (adv) begin
                cnt_reg      <= cnt_next;
                leader_reg   <= leader_next;
                rpt_lead_reg <= rpt_lead_next;
                bit_err_reg  <= bit_err_next;
                shift_reg    <= shift_next;
                addr_reg     <= addr_next;
                cmd_reg      <= cmd_next;
            end

            if (adv && in_last_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_mark_reg  <= s_tdata[DW-1:0];
            in_space_reg <= s_tdata[2*DW-1:DW];
            in_last_reg  <= s_tlast;
        end
        if (adv && in_last_reg) begin
            out_ok_reg   <= res_ok;
            out_rpt_reg  <= res_rpt;
            out_data_reg <= {cmd_next, addr_next};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = {out_rpt_reg, out_ok_reg};

`ifndef SYNTH
    // symbol counter saturates
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_SYMBOLS))
        else $error("symbol count above limit");

    // a repeat result is always also a good result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[1] && !m_tuser[0]))
        else $error("repeat flagged on failed capture");

    // capture state is cleared after each end of capture
    assert property (@(posedge aclk) disable iff (!aresetn)
        adv && in_last_reg |=> cnt_reg == '0 && !leader_reg && !rpt_lead_reg && !bit_err_reg)
        else $error("capture state not cleared");

    // a result is never loaded over one that has not been taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        adv && in_last_reg && out_valid_reg |-> m_tready)
        else $error("result overwritten");

    // held values change only on a good full frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(adv && in_last_reg && res_ok && !res_rpt) |=> $stable(addr_reg) && $stable(cmd_reg))
        else $error("held address or command changed without a frame");
`endif

endmodule
